// ===== rtl/core/sbvg_pkg.sv =====
// Shared widths, payload types and face tables for the sky box vertex generator.
package sbvg_pkg;

  localparam int EYE_W  = 24;
  localparam int FACE_W = 3;
  localparam int GRID_W = 3;
  localparam int CRN_W  = 2;
  localparam int OPOS_W = 13;
  localparam int TEX_W  = 17;
  localparam int CIDX_W = 2;

  // Internal position: half size plus eight steps at the largest box size.
  localparam int POS_W  = 20;
  localparam int AB_W   = GRID_W + 1;
  localparam int D_W    = 26;
  localparam int MAG_W  = 27;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int WIDE_W = 96;
  localparam int NSTG   = TEX_W;

  localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;

  localparam logic [CRN_W-1:0] CORNER_BASE = 2'd0;
  localparam logic [CRN_W-1:0] CORNER_U    = 2'd1;
  localparam logic [CRN_W-1:0] CORNER_UV   = 2'd2;
  localparam logic [CRN_W-1:0] CORNER_V    = 2'd3;

  localparam logic [CIDX_W-1:0] REG_EYE_X = 2'd0;
  localparam logic [CIDX_W-1:0] REG_EYE_Y = 2'd1;
  localparam logic [CIDX_W-1:0] REG_EYE_Z = 2'd2;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  typedef struct packed {
    pos_t  pos_x;
    pos_t  pos_y;
    pos_t  pos_z;
    logic  neg_x;
    logic  neg_y;
    logic  degen;
  } side_t;

  // Bit i set: base corner sits on the positive side of axis i.
  function automatic logic [2:0] base_pos_mask(input logic [FACE_W-1:0] face);
    logic [2:0] m;
    case (face)
      3'd0:    m = 3'b100;
      3'd1:    m = 3'b001;
      3'd2:    m = 3'b010;
      3'd3:    m = 3'b011;
      3'd4:    m = 3'b110;
      3'd5:    m = 3'b101;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] u_axis(input logic [FACE_W-1:0] face);
    logic [1:0] r;
    case (face)
      3'd0, 3'd3: r = 2'd0;
      3'd1, 3'd4: r = 2'd1;
      3'd2, 3'd5: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] v_axis(input logic [FACE_W-1:0] face);
    logic [1:0] r;
    case (face)
      3'd0, 3'd3: r = 2'd1;
      3'd1, 3'd4: r = 2'd2;
      3'd2, 3'd5: r = 2'd0;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/sbvg_front.sv =====
// Front pipeline: vertex position, eye offset, squares and length terms.
module sbvg_front import sbvg_pkg::*; #(
  parameter int STEP = 1000,
  parameter int HALF = 4000
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [FACE_W-1:0]        face,
  input  logic [GRID_W-1:0]        grid_row,
  input  logic [GRID_W-1:0]        grid_column,
  input  logic [CRN_W-1:0]         quad_corner,
  input  logic signed [EYE_W-1:0]  eye_x,
  input  logic signed [EYE_W-1:0]  eye_y,
  input  logic signed [EYE_W-1:0]  eye_z,
  output logic                     out_vld,
  output side_t                    side,
  output wide_t                    len,
  output wide_t                    t2x,
  output wide_t                    t2y
);

  // stage 1: position
  logic       v1_r, v1_nxt;
  pos_t       p1_r [3];
  pos_t       p1_nxt [3];
  // stage 2: offset magnitudes
  logic       v2_r;
  pos_t       p2_r [3];
  logic [MAG_W-1:0] m2_r [3];
  logic [MAG_W-1:0] m2_nxt [3];
  logic       nx2_r, ny2_r;
  logic signed [D_W-1:0]   dx, dy, dz;
  logic signed [D_W+1:0]   dz3;
  // stage 3: squares
  logic       v3_r;
  pos_t       p3_r [3];
  logic [SQ_W-1:0] s3_r [3];
  logic       nx3_r, ny3_r, z3_r;
  // stage 4: length and target terms
  logic       v4_r;
  side_t      side_r;
  wide_t      len_r, t2x_r, t2y_r;

  logic [AB_W-1:0] a_cnt, b_cnt;
  pos_t            a_stp, b_stp;
  logic [2:0]      bmask;
  logic [1:0]      ua, va;

  always_comb begin
    a_cnt = {1'b0, grid_row} +
            AB_W'((quad_corner == CORNER_U) || (quad_corner == CORNER_UV));
    b_cnt = {1'b0, grid_column} +
            AB_W'((quad_corner == CORNER_UV) || (quad_corner == CORNER_V));
    a_stp = POS_W'(a_cnt) * POS_W'(STEP);
    b_stp = POS_W'(b_cnt) * POS_W'(STEP);
    bmask = base_pos_mask(face);
    ua    = u_axis(face);
    va    = v_axis(face);
    v1_nxt = in_vld && (face <= FACE_LAST);
    for (int i = 0; i < 3; i++) begin
      p1_nxt[i] = bmask[i] ? POS_W'(HALF) : -POS_W'(HALF);
      if (ua == 2'(i))
        p1_nxt[i] = (face > 3'd2) ? p1_nxt[i] - a_stp : p1_nxt[i] + a_stp;
      else if (va == 2'(i))
        p1_nxt[i] = (face > 3'd2) ? p1_nxt[i] - b_stp : p1_nxt[i] + b_stp;
    end
  end

  always_comb begin
    dx  = (D_W'(p1_r[0]) <<< 4) - D_W'(eye_x);
    dy  = (D_W'(p1_r[1]) <<< 4) - D_W'(eye_y);
    dz  = (D_W'(p1_r[2]) <<< 4) - D_W'(eye_z);
    dz3 = (D_W+2)'(dz) * (D_W+2)'(3);
    m2_nxt[0] = dx[D_W-1]   ? MAG_W'(-dx)  : MAG_W'(dx);
    m2_nxt[1] = dy[D_W-1]   ? MAG_W'(-dy)  : MAG_W'(dy);
    m2_nxt[2] = dz3[D_W+1]  ? MAG_W'(-dz3) : MAG_W'(dz3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      p2_r  <= p1_r;
      m2_r  <= m2_nxt;
      nx2_r <= dx[D_W-1];
      ny2_r <= dy[D_W-1];
      p3_r  <= p2_r;
      for (int i = 0; i < 3; i++)
        s3_r[i] <= SQ_W'(m2_r[i]) * SQ_W'(m2_r[i]);
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      z3_r  <= (m2_r[0] == '0) && (m2_r[1] == '0) && (m2_r[2] == '0);
      side_r.pos_x <= p3_r[0];
      side_r.pos_y <= p3_r[1];
      side_r.pos_z <= p3_r[2];
      side_r.neg_x <= nx3_r;
      side_r.neg_y <= ny3_r;
      side_r.degen <= z3_r;
      len_r <= wide_t'(s3_r[0]) + wide_t'(s3_r[1]) + wide_t'(s3_r[2]);
      // 9 * m^2 * 2^30 is the square of 2 * 3.0 * m in Q2.14
      t2x_r <= ((wide_t'(s3_r[0]) <<< 3) + wide_t'(s3_r[0])) <<< 30;
      t2y_r <= ((wide_t'(s3_r[1]) <<< 3) + wide_t'(s3_r[1])) <<< 30;
    end
  end

  assign out_vld = v4_r;
  assign side    = side_r;
  assign len     = len_r;
  assign t2x     = t2x_r;
  assign t2y     = t2y_r;

endmodule

// ===== rtl/core/sbvg_search.sv =====
// Bit-per-stage search for the rounded scaled coordinate magnitude.
module sbvg_search import sbvg_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  wide_t            len,
  input  wide_t            t2,
  output logic [TEX_W-1:0] q
);

  // Track k = 2q-1 through P = k*k*len and Q = k*len; accept a bit while
  // the trial P stays at or below t2.
  wide_t            p_r [NSTG];
  wide_t            k_r [NSTG];
  wide_t            l_r [NSTG];
  wide_t            t_r [NSTG];
  logic [TEX_W-1:0] q_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int J = NSTG - 1 - s;
    wide_t            p_in, k_in, l_in, t_in, trial;
    logic [TEX_W-1:0] q_in;
    logic             ok;

    if (s == 0) begin : g_first
      assign p_in = len;
      assign k_in = -len;
      assign l_in = len;
      assign t_in = t2;
      assign q_in = '0;
    end else begin : g_next
      assign p_in = p_r[s-1];
      assign k_in = k_r[s-1];
      assign l_in = l_r[s-1];
      assign t_in = t_r[s-1];
      assign q_in = q_r[s-1];
    end

    assign trial = p_in + (k_in <<< (J + 2)) + (l_in <<< (2 * J + 2));
    assign ok    = (trial <= t_in);

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[s] <= ok ? trial : p_in;
        k_r[s] <= ok ? k_in + (l_in <<< (J + 1)) : k_in;
        q_r[s] <= ok ? (q_in | (TEX_W'(1) << J)) : q_in;
        l_r[s] <= l_in;
        t_r[s] <= t_in;
      end
    end
  end

  assign q = q_r[NSTG-1];

endmodule

// ===== rtl/core/sky_box_vertex_generator.sv =====
// Top level of the sky box vertex generator: registers, pipeline and output stage.
//
//  channel | direction | payload                                   | accept
//  in_     | slave     | tdata: face, grid_row, grid_column, corner | tvalid & tready
//  out_    | master    | tdata: pos_x/y/z, tex_s, tex_t; tuser: deg | tvalid & tready
//  cfg_    | slave     | index 0..2 = eye_x/y/z, 24-bit data        | valid & ready
//
//  One vertex enters per cycle unless the pipeline holds. The path has four front stages
//  (position, eye offset, squares, length), seventeen search stages (one
//  result bit each) and the output register.
//  Items naming face six or seven are taken and dropped.
//  Reset clears the valid bits and the eye registers to zero.
//  The whole pipeline advances together; it holds while a result waits and
//  out_tready is low, and accepts a new word whenever the output moves.
module sky_box_vertex_generator import sbvg_pkg::*; #(
  parameter int GRID_DIVISIONS = 8,
  parameter int BOX_SIZE       = 8000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // face[2:0], grid_row[5:3], grid_column[8:6],
                                         // quad_corner[10:9], zero fill
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [79:0]        out_tdata,  // pos_x[12:0], pos_y[25:13], pos_z[38:26],
                                         // tex_s[55:39], tex_t[72:56], zero fill
  output logic               out_tuser,  // degenerate
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [EYE_W-1:0]   cfg_data
);

  localparam int STEP = BOX_SIZE / GRID_DIVISIONS;
  localparam int HALF = BOX_SIZE / 2;

  logic signed [EYE_W-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic                    en;
  logic                    fv;
  side_t                   fside;
  wide_t                   flen, ft2x, ft2y;
  logic [TEX_W-1:0]        qx, qy;

  logic                    dv_r [NSTG];
  side_t                   ds_r [NSTG];

  logic                    ov_r;
  logic signed [OPOS_W-1:0] opx_r, opy_r, opz_r;
  logic signed [TEX_W-1:0] tex_s_r, tex_t_r, tex_s_nxt, tex_t_nxt;
  logic                    deg_r;

  // Advance everything when the output slot is free or being drained.
  assign en        = !ov_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EYE_X: eye_x_r <= cfg_data;
        REG_EYE_Y: eye_y_r <= cfg_data;
        REG_EYE_Z: eye_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sbvg_front #(
    .STEP (STEP),
    .HALF (HALF)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_tvalid),
    .face        (in_tdata[2:0]),
    .grid_row    (in_tdata[5:3]),
    .grid_column (in_tdata[8:6]),
    .quad_corner (in_tdata[10:9]),
    .eye_x       (eye_x_r),
    .eye_y       (eye_y_r),
    .eye_z       (eye_z_r),
    .out_vld     (fv),
    .side        (fside),
    .len         (flen),
    .t2x         (ft2x),
    .t2y         (ft2y)
  );

  sbvg_search u_srch_s (
    .clk (clk),
    .en  (en),
    .len (flen),
    .t2  (ft2x),
    .q   (qx)
  );

  sbvg_search u_srch_t (
    .clk (clk),
    .en  (en),
    .len (flen),
    .t2  (ft2y),
    .q   (qy)
  );

  // Carry position, signs and valid alongside the search stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++)
        dv_r[s] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= fv;
      for (int s = 1; s < NSTG; s++)
        dv_r[s] <= dv_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= fside;
      for (int s = 1; s < NSTG; s++)
        ds_r[s] <= ds_r[s-1];
    end
  end

  // Apply the sign; a zero offset forces both coordinates to zero.
  always_comb begin
    tex_s_nxt = ds_r[NSTG-1].neg_x ? -$signed(qx) : $signed(qx);
    tex_t_nxt = ds_r[NSTG-1].neg_y ? -$signed(qy) : $signed(qy);
    if (ds_r[NSTG-1].degen) begin
      tex_s_nxt = '0;
      tex_t_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opx_r   <= ds_r[NSTG-1].pos_x[OPOS_W-1:0];
      opy_r   <= ds_r[NSTG-1].pos_y[OPOS_W-1:0];
      opz_r   <= ds_r[NSTG-1].pos_z[OPOS_W-1:0];
      tex_s_r <= tex_s_nxt;
      tex_t_r <= tex_t_nxt;
      deg_r   <= ds_r[NSTG-1].degen;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, tex_t_r, tex_s_r, opz_r, opy_r, opx_r};
  assign out_tuser  = deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (tex_s_r == '0) && (tex_t_r == '0))
    else $error("degenerate vertex with nonzero texture coordinate");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (tex_s_r <= 17'sd49152) && (tex_s_r >= -17'sd49152) &&
                   (tex_t_r <= 17'sd49152) && (tex_t_r >= -17'sd49152))
    else $error("texture coordinate beyond three");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
